// ===== hw/rtl/modular_inverse_defines.svh =====
// ----------------------------------------------------------------------------
// Modular inverse assertion macros
// Shared concurrent assertion forms for the modular inverse RTL.
// ----------------------------------------------------------------------------
`ifndef MODULAR_INVERSE_DEFINES_SVH
`define MODULAR_INVERSE_DEFINES_SVH

// same-cycle implication
`define MINV_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MINV_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/minv_pkg.sv =====
// ----------------------------------------------------------------------------
// Modular inverse package
// Widths, beat types, microcode word format and the control program.
// ----------------------------------------------------------------------------
`default_nettype none

package minv_pkg;

   localparam int WordBits  = 31;
   localparam int CoefBits  = WordBits + 2;
   localparam int CountBits = $clog2(WordBits + 1);
   localparam int StepBits  = 4;

   typedef logic [WordBits-1:0]        word_type;
   typedef logic signed [CoefBits-1:0] coef_type;
   typedef logic [CountBits-1:0]       count_type;
   typedef logic [StepBits-1:0]        step_type;

   typedef struct packed {
      logic [30:0] value;
      logic [30:0] modulus;
   } req_type;

   typedef struct packed {
      logic [30:0] inverse;
      logic        found;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_START_RED,
      OP_LOAD_R1,
      OP_START_DIV,
      OP_MUL,
      OP_UPDATE,
      OP_FIX_NEG,
      OP_FIX_HIGH,
      OP_FAIL,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      CND_NEXT,
      CND_ALWAYS,
      CND_NO_REQ,
      CND_MOD_ZERO,
      CND_DIV_BUSY,
      CND_R1_ZERO,
      CND_R0_NOT_ONE,
      CND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_type;

   typedef struct packed {
      logic mod_zero;
      logic div_busy;
      logic r1_zero;
      logic r0_not_one;
      logic out_busy;
   } status_type;

   localparam step_type StepWait    = step_type'(0);
   localparam step_type StepModChk  = step_type'(1);
   localparam step_type StepRed     = step_type'(2);
   localparam step_type StepRedWait = step_type'(3);
   localparam step_type StepLoadR1  = step_type'(4);
   localparam step_type StepLoop    = step_type'(5);
   localparam step_type StepDiv     = step_type'(6);
   localparam step_type StepDivWait = step_type'(7);
   localparam step_type StepMul     = step_type'(8);
   localparam step_type StepUpdate  = step_type'(9);
   localparam step_type StepFin     = step_type'(10);
   localparam step_type StepFixNeg  = step_type'(11);
   localparam step_type StepFixHigh = step_type'(12);
   localparam step_type StepFail    = step_type'(13);
   localparam step_type StepEmit    = step_type'(14);
   localparam step_type StepBack    = step_type'(15);

   // control program: a jump is taken when its condition holds, else step+1
   function automatic ctrl_type microcode(input step_type step);
      ctrl_type word;
      word = '{op: OP_NONE, cond: CND_NEXT, target: StepWait};
      case (step)
         StepWait:    word = '{op: OP_ACCEPT,    cond: CND_NO_REQ,     target: StepWait};
         StepModChk:  word = '{op: OP_NONE,      cond: CND_MOD_ZERO,   target: StepFail};
         StepRed:     word = '{op: OP_START_RED, cond: CND_NEXT,       target: StepWait};
         StepRedWait: word = '{op: OP_NONE,      cond: CND_DIV_BUSY,   target: StepRedWait};
         StepLoadR1:  word = '{op: OP_LOAD_R1,   cond: CND_NEXT,       target: StepWait};
         StepLoop:    word = '{op: OP_NONE,      cond: CND_R1_ZERO,    target: StepFin};
         StepDiv:     word = '{op: OP_START_DIV, cond: CND_NEXT,       target: StepWait};
         StepDivWait: word = '{op: OP_NONE,      cond: CND_DIV_BUSY,   target: StepDivWait};
         StepMul:     word = '{op: OP_MUL,       cond: CND_NEXT,       target: StepWait};
         StepUpdate:  word = '{op: OP_UPDATE,    cond: CND_ALWAYS,     target: StepLoop};
         StepFin:     word = '{op: OP_NONE,      cond: CND_R0_NOT_ONE, target: StepFail};
         StepFixNeg:  word = '{op: OP_FIX_NEG,   cond: CND_NEXT,       target: StepWait};
         StepFixHigh: word = '{op: OP_FIX_HIGH,  cond: CND_ALWAYS,     target: StepEmit};
         StepFail:    word = '{op: OP_FAIL,      cond: CND_NEXT,       target: StepWait};
         StepEmit:    word = '{op: OP_EMIT,      cond: CND_OUT_BUSY,   target: StepEmit};
         StepBack:    word = '{op: OP_NONE,      cond: CND_ALWAYS,     target: StepWait};
         default:     word = '{op: OP_NONE,      cond: CND_ALWAYS,     target: StepWait};
      endcase
      return word;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/modular_inverse.sv =====
// ----------------------------------------------------------------------------
// Modular inverse
// Extended Euclid inverse of value modulo modulus, run by a microcoded
// sequencer over a divider/multiplier datapath.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Beat
// req      in         req_valid / req_stall  value, modulus
// rsp      out        rsp_valid / rsp_stall  inverse, found
//
// One item at a time. After the accept the bit-serial divider runs the first
// reduction, then each Euclid quotient step divides, multiplies and updates;
// then the sequencer fixes up the result (skipped when not found), emits it
// and returns to wait. A zero modulus goes straight to the fail and emit steps.
// Reset clears the step counter, divider control and output valid.
// The result sits in an output register; a new item is taken while it
// waits, and the sequencer only holds at the emit step if the register is
// still full and stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_inverse (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire minv_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output minv_pkg::rsp_type      rsp_data
);

   minv_pkg::op_type     op;
   minv_pkg::status_type status;

   minv_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .op        (op)
   );

   minv_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .status    (status)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/minv_div.sv =====
// ----------------------------------------------------------------------------
// Modular inverse divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "modular_inverse_defines.svh"

module minv_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire minv_pkg::word_type dividend,
   input  wire minv_pkg::word_type divisor,
   output logic                    busy,
   output minv_pkg::word_type      quot,
   output minv_pkg::word_type      rem
);

   localparam int W = minv_pkg::WordBits;

   logic                busy_ff, busy_in;
   minv_pkg::count_type cnt_ff, cnt_in;
   minv_pkg::word_type  rem_ff, rem_in;
   minv_pkg::word_type  quo_ff, quo_in;
   minv_pkg::word_type  dvs_ff, dvs_in;
   logic [W:0]          shifted;
   logic [W+1:0]        trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[W-1]};
      trial   = {1'b0, shifted} - {2'b00, dvs_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = minv_pkg::count_type'(W);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!trial[W+1]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != minv_pkg::count_type'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy = busy_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;

   `MINV_ASSERT_NXT(a_start_busy, clock, reset, start, busy_ff, "divider did not start")
   `MINV_ASSERT_IMP(a_rem_below, clock, reset, $fell(busy_ff), rem_ff < dvs_ff, "remainder not below divisor")
   `MINV_ASSERT_IMP(a_dvs_nonzero, clock, reset, busy_ff, dvs_ff != '0, "division by zero")

endmodule

`default_nettype wire

// ===== hw/rtl/minv_dp.sv =====
// ----------------------------------------------------------------------------
// Modular inverse datapath
// Remainder and coefficient registers, divider, multiplier, output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "modular_inverse_defines.svh"

module minv_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire minv_pkg::op_type     op,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire minv_pkg::req_type    req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output minv_pkg::rsp_type         rsp_data,
   output minv_pkg::status_type      status
);

   localparam int W  = minv_pkg::WordBits;
   localparam int CW = minv_pkg::CoefBits;

   minv_pkg::word_type a_ff, a_in;
   minv_pkg::word_type n_ff, n_in;
   minv_pkg::word_type r0_ff, r0_in;
   minv_pkg::word_type r1_ff, r1_in;
   minv_pkg::coef_type t0_ff, t0_in;
   minv_pkg::coef_type t1_ff, t1_in;
   minv_pkg::coef_type prod_ff, prod_in;
   logic               found_ff, found_in;
   logic               out_valid_ff, out_valid_in;
   minv_pkg::rsp_type  out_data_ff, out_data_in;

   logic                  div_start;
   minv_pkg::word_type    div_dividend;
   minv_pkg::word_type    div_divisor;
   logic                  div_busy;
   minv_pkg::word_type    div_quot;
   minv_pkg::word_type    div_rem;
   logic signed [W+CW:0]  product;
   minv_pkg::coef_type    n_coef;
   logic                  out_busy;

   minv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   assign div_start    = (op == minv_pkg::OP_START_RED) || (op == minv_pkg::OP_START_DIV);
   assign div_dividend = (op == minv_pkg::OP_START_RED) ? a_ff : r0_ff;
   assign div_divisor  = (op == minv_pkg::OP_START_RED) ? n_ff : r1_ff;

   assign product  = $signed({1'b0, div_quot}) * t1_ff;
   assign n_coef   = $signed({{(CW - W){1'b0}}, n_ff});
   assign out_busy = out_valid_ff && rsp_stall;

   always_comb begin
      a_in         = a_ff;
      n_in         = n_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      t0_in        = t0_ff;
      t1_in        = t1_ff;
      prod_in      = prod_ff;
      found_in     = found_ff;
      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      unique case (op)
         minv_pkg::OP_ACCEPT: begin
            if (req_valid) begin
               a_in = req_data.value[W-1:0];
               n_in = req_data.modulus[W-1:0];
            end
         end
         minv_pkg::OP_START_RED: begin
            r0_in = n_ff;
            t0_in = '0;
            t1_in = minv_pkg::coef_type'(1);
         end
         minv_pkg::OP_LOAD_R1: begin
            r1_in = div_rem;
         end
         minv_pkg::OP_MUL: begin
            prod_in = product[CW-1:0];
         end
         minv_pkg::OP_UPDATE: begin
            r0_in = r1_ff;
            r1_in = div_rem;
            t0_in = t1_ff;
            t1_in = t0_ff - prod_ff;
         end
         minv_pkg::OP_FIX_NEG: begin
            if (t0_ff[CW-1]) t0_in = t0_ff + n_coef;
         end
         minv_pkg::OP_FIX_HIGH: begin
            if (t0_ff >= n_coef) t0_in = t0_ff - n_coef;
            found_in = 1'b1;
         end
         minv_pkg::OP_FAIL: begin
            t0_in    = '0;
            found_in = 1'b0;
         end
         minv_pkg::OP_EMIT: begin
            if (!out_busy) begin
               out_valid_in        = 1'b1;
               out_data_in.inverse = 31'(t0_ff[W-1:0]);
               out_data_in.found   = found_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      a_ff        <= a_in;
      n_ff        <= n_in;
      r0_ff       <= r0_in;
      r1_ff       <= r1_in;
      t0_ff       <= t0_in;
      t1_ff       <= t1_in;
      prod_ff     <= prod_in;
      found_ff    <= found_in;
      out_data_ff <= out_data_in;
   end

   assign req_stall = (op != minv_pkg::OP_ACCEPT);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign status.mod_zero   = (n_ff == '0);
   assign status.div_busy   = div_busy;
   assign status.r1_zero    = (r1_ff == '0);
   assign status.r0_not_one = (r0_ff != minv_pkg::word_type'(1));
   assign status.out_busy   = out_busy;

   `MINV_ASSERT_IMP(a_start_idle, clock, reset, div_start, !div_busy, "divider restarted while busy")
   `MINV_ASSERT_IMP(a_rem_shrinks, clock, reset, op == minv_pkg::OP_UPDATE, div_rem < r1_ff, "remainder did not shrink")
   `MINV_ASSERT_IMP(a_inv_range, clock, reset, (op == minv_pkg::OP_EMIT) && !out_busy && found_ff, !t0_ff[CW-1] && (t0_ff < n_coef), "inverse out of range")

endmodule

`default_nettype wire

// ===== hw/rtl/minv_seq.sv =====
// ----------------------------------------------------------------------------
// Modular inverse sequencer
// Step counter over the microcode ROM with conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module minv_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire minv_pkg::status_type status,
   output minv_pkg::op_type          op
);

   minv_pkg::step_type pc_ff, pc_in;
   minv_pkg::ctrl_type ctrl;
   logic               take;

   always_comb begin
      ctrl = minv_pkg::microcode(pc_ff);
      unique case (ctrl.cond)
         minv_pkg::CND_NEXT:       take = 1'b0;
         minv_pkg::CND_ALWAYS:     take = 1'b1;
         minv_pkg::CND_NO_REQ:     take = !req_valid;
         minv_pkg::CND_MOD_ZERO:   take = status.mod_zero;
         minv_pkg::CND_DIV_BUSY:   take = status.div_busy;
         minv_pkg::CND_R1_ZERO:    take = status.r1_zero;
         minv_pkg::CND_R0_NOT_ONE: take = status.r0_not_one;
         minv_pkg::CND_OUT_BUSY:   take = status.out_busy;
         default:                  take = 1'b0;
      endcase
      pc_in = take ? ctrl.target : pc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= minv_pkg::StepWait;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign op = ctrl.op;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Modular inverse testbench
// Drives value/modulus beats into modular_inverse and checks every result
// beat against its table row or an extended Euclid predictor. A table of
// edge cases runs first, then random operands with varied modulus widths
// over three idling phases, a long result hold-off and a full drain between.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int StepCap        = 2 * minv_pkg::WordBits + 2;
   localparam int RandomPerPhase = 545;
   localparam int HoldCycles     = 3000;
   localparam int TailCycles     = 2000;
   localparam int NumProbes      = 21;

   typedef struct packed {
      logic [30:0] value;
      logic [30:0] modulus;
      logic        typed;     // expected result given in the row
      logic [30:0] inverse;
      logic        found;
   } probe_row_type;

   typedef struct packed {
      minv_pkg::req_type operands;
      minv_pkg::rsp_type outcome;
   } inverse_job_type;

   // edge cases; untyped rows go through the predictor
   localparam probe_row_type Probes [NumProbes] = '{
      '{31'd5,          31'd0,          1'b1, 31'd0,          1'b0},  // zero modulus
      '{31'd0,          31'd0,          1'b1, 31'd0,          1'b0},
      '{31'h7FFFFFFF,   31'd0,          1'b1, 31'd0,          1'b0},
      '{31'd0,          31'd1,          1'b1, 31'd0,          1'b1},  // modulus one
      '{31'h7FFFFFFF,   31'd1,          1'b1, 31'd0,          1'b1},
      '{31'd0,          31'd5,          1'b1, 31'd0,          1'b0},  // zero value
      '{31'd0,          31'h7FFFFFFF,   1'b1, 31'd0,          1'b0},
      '{31'd1,          31'd7,          1'b1, 31'd1,          1'b1},
      '{31'd6,          31'd9,          1'b1, 31'd0,          1'b0},  // common factor
      '{31'd10,         31'd7,          1'b1, 31'd5,          1'b1},  // value above modulus
      '{31'h7FFFFFFF,   31'h7FFFFFFF,   1'b1, 31'd0,          1'b0},
      '{31'h7FFFFFFE,   31'h7FFFFFFF,   1'b1, 31'h7FFFFFFE,   1'b1},
      '{31'd2,          31'h7FFFFFFF,   1'b1, 31'h40000000,   1'b1},
      '{31'd1,          31'h7FFFFFFF,   1'b1, 31'd1,          1'b1},
      '{31'd1,          31'd2,          1'b1, 31'd1,          1'b1},
      '{31'd3,          31'd2,          1'b1, 31'd1,          1'b1},
      '{31'd1134903170, 31'd1836311903, 1'b0, 31'd0,          1'b0},  // longest chain
      '{31'h7FFFFFFF,   31'h40000000,   1'b0, 31'd0,          1'b0},
      '{31'd3,          31'h7FFFFFFF,   1'b0, 31'd0,          1'b0},
      '{31'd12345,      31'h7FFFFFFE,   1'b0, 31'd0,          1'b0},
      '{31'h55555555,   31'h2AAAAAAA,   1'b0, 31'd0,          1'b0}
   };

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   minv_pkg::req_type req_data  = '0;
   logic              rsp_stall = 1'b0;
   logic              req_stall;
   logic              rsp_valid;
   minv_pkg::rsp_type rsp_data;

   inverse_job_type pending_results [$];
   int              error_count   = 0;
   int unsigned     send_idle_pct = 0;
   int unsigned     recv_idle_pct = 0;
   int              rsp_hold_left = 0;

   modular_inverse u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("** modular_inverse: FAILED **");
      $finish;
   end

   // extended Euclid, coefficient of value only, wrapping 64-bit arithmetic
   function automatic minv_pkg::rsp_type euclid_inverse(input logic [30:0] value,
                                                        input logic [30:0] modulus);
      logic [63:0]       r0, r1, t0, t1, q, nr, nt;
      minv_pkg::rsp_type res;
      int                k;
      res = '0;
      if (modulus == '0) return res;
      r0 = 64'(modulus);
      r1 = 64'(value) % 64'(modulus);
      t0 = '0;
      t1 = 64'd1;
      for (k = 0; k < StepCap && r1 != '0; k++) begin
         q  = r0 / r1;
         nr = r0 - q * r1;
         nt = t0 - q * t1;
         r0 = r1;
         r1 = nr;
         t0 = t1;
         t1 = nt;
      end
      if (r0 != 64'd1) return res;
      if (t0[63]) t0 = t0 + 64'(modulus);
      if (t0 >= 64'(modulus)) t0 = t0 % 64'(modulus);
      res.inverse = t0[30:0];
      res.found   = 1'b1;
      return res;
   endfunction

   function automatic minv_pkg::req_type random_operands();
      minv_pkg::req_type beat;
      int unsigned       width, pick, factor;
      width        = $urandom_range(31, 1);
      pick         = $urandom_range(99);
      beat.modulus = 31'($urandom >> (32 - width));
      beat.value   = 31'($urandom >> (32 - width));
      if (pick < 45) begin
         // same width as the modulus: keep as drawn
      end else if (pick < 60) begin
         beat.value = 31'($urandom);
      end else if (pick < 72) begin
         factor       = $urandom_range(60, 2);
         beat.modulus = 31'(factor * $urandom_range(1 << 24, 1));
         beat.value   = 31'(factor * $urandom_range(1 << 24, 0));
      end else if (pick < 78) begin
         beat.modulus = '0;
      end else if (pick < 84) begin
         beat.modulus = 31'd1;
      end else if (pick < 90) begin
         beat.value = '0;
      end else begin
         beat.modulus = 31'($urandom);
         beat.value   = 31'($urandom);
      end
      return beat;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   task automatic check_result(input minv_pkg::rsp_type got);
      inverse_job_type job;
      if (pending_results.size() == 0) begin
         report_mismatch($sformatf("result with nothing pending: inverse=%0d found=%0b",
                                   got.inverse, got.found));
         return;
      end
      job = pending_results.pop_front();
      if (got.inverse !== job.outcome.inverse)
         report_mismatch($sformatf("value=%0d modulus=%0d: inverse %0d, want %0d",
                                   job.operands.value, job.operands.modulus,
                                   got.inverse, job.outcome.inverse));
      if (got.found !== job.outcome.found)
         report_mismatch($sformatf("value=%0d modulus=%0d: found %0b, want %0b",
                                   job.operands.value, job.operands.modulus,
                                   got.found, job.outcome.found));
   endtask

   // result side: check at the edge, then pick the stall for the next cycle
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) check_result(rsp_data);
         if (rsp_hold_left > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   task automatic offer_operands(input minv_pkg::req_type beat,
                                 input minv_pkg::rsp_type outcome);
      inverse_job_type job;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_data  <= minv_pkg::req_type'({$urandom, $urandom});
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      job.operands = beat;
      job.outcome  = outcome;
      pending_results.push_back(job);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   initial begin
      minv_pkg::req_type beat;
      minv_pkg::rsp_type outcome;
      int                phase;
      int                i;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 38;
      recv_idle_pct = 75;
      for (i = 0; i < NumProbes; i++) begin
         beat.value   = Probes[i].value;
         beat.modulus = Probes[i].modulus;
         if (Probes[i].typed) begin
            outcome.inverse = Probes[i].inverse;
            outcome.found   = Probes[i].found;
         end else begin
            outcome = euclid_inverse(beat.value, beat.modulus);
         end
         offer_operands(beat, outcome);
      end
      drain_results();

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 38;
               recv_idle_pct = 75;
            end
            1: begin
               send_idle_pct = 75;
               recv_idle_pct = 38;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (i = 0; i < RandomPerPhase; i++) begin
            // long result hold-off: the output register fills and input backs up
            if (phase == 2 && i == 0) rsp_hold_left = HoldCycles;
            // sender goes quiet until every pending result is back
            if (phase == 1 && i == RandomPerPhase / 2) drain_results();
            beat = random_operands();
            offer_operands(beat, euclid_inverse(beat.value, beat.modulus));
         end
      end

      drain_results();
      repeat (TailCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("** modular_inverse: PASSED **");
      end else begin
         $display("** modular_inverse: FAILED **");
      end
      $finish;
   end

endmodule
